>>> rtl/register_bytecode_executor_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the register bytecode executor
// Clocked, reset-gated concurrent assertion forms.
// ----------------------------------------------------------------------------
`ifndef REGISTER_BYTECODE_EXECUTOR_DEFINES_SVH
`define REGISTER_BYTECODE_EXECUTOR_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define RBE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold at every clock edge outside reset.
`define RBE_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

>>> rtl/rbe_pkg.sv
// ----------------------------------------------------------------------------
// rbe_pkg
// Shared types and constants of the register bytecode executor.
// ----------------------------------------------------------------------------
package rbe_pkg;

  localparam int unsigned NumRegs = 256;
  localparam int unsigned RegIdxW = (NumRegs > 1) ? $clog2(NumRegs) : 1;
  localparam int unsigned DataW   = 64;
  localparam int unsigned DivCntW = 7;

  typedef enum logic [3:0] {
    K_NOP       = 4'd0,
    K_LOADI     = 4'd1,
    K_LOADINEG  = 4'd2,
    K_LOADSMALL = 4'd3,
    K_ADD       = 4'd4,
    K_ADDI      = 4'd5,
    K_SUB       = 4'd6,
    K_SUBI      = 4'd7,
    K_MUL       = 4'd8,
    K_DIV       = 4'd9,
    K_RETURN    = 4'd10
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_DIVZERO = 2'd1,
    ERR_RANGE   = 2'd2
  } err_e;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] reg_index;
    logic [7:0] imm_value;
    logic signed [3:0] small_const;
  } instr_t;

  typedef struct packed {
    logic done_res;
    logic signed [63:0] ret_value;
    logic [1:0] error_code;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic clr_en;      // clear-sweep write of entry clr_addr
    logic capture;     // latch instruction
    logic rd_a;        // read r[a] into x
    logic rd_b;        // read r[a+1] into y
    logic mul_lo;      // partial products, low half
    logic mul_hi;      // partial products, high terms
    logic div_start;
    logic div_step;
    logic write_back;  // write result to r[a], build result item
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [3:0] kind;
    logic a_ok;
    logic b_ok;
    logic div_last;
  } stat_t;

endpackage

>>> rtl/rbe_if.sv
// ----------------------------------------------------------------------------
// rbe_instr_if / rbe_result_if
// Valid/ready channels for instructions and results.
// ----------------------------------------------------------------------------
interface rbe_instr_if;
  logic valid;
  logic ready;
  logic [3:0] kind;
  logic [7:0] reg_index;
  logic [7:0] imm_value;
  logic signed [3:0] small_const;
  modport source (output valid, kind, reg_index, imm_value, small_const, input ready);
  modport sink (input valid, kind, reg_index, imm_value, small_const, output ready);
endinterface

interface rbe_result_if;
  logic valid;
  logic ready;
  logic done_res;
  logic signed [63:0] ret_value;
  logic [1:0] error_code;
  modport source (output valid, done_res, ret_value, error_code, input ready);
  modport sink (input valid, done_res, ret_value, error_code, output ready);
endinterface

>>> rtl/rbe_ctrl.sv
// ----------------------------------------------------------------------------
// rbe_ctrl
// Sequencer: clear sweep, capture, register reads, multiply and divide steps, write-back.
// ----------------------------------------------------------------------------
module rbe_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_free_i,
  input  rbe_pkg::stat_t  stat_i,
  output rbe_pkg::cmd_t   cmd_o,
  output logic [rbe_pkg::RegIdxW-1:0] clr_addr_o,
  output logic            busy_o
);
  import rbe_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_RDA   = 8'b0000_0100,
    S_RDB   = 8'b0000_1000,
    S_MUL1  = 8'b0001_0000,
    S_MUL2  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_WB    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [RegIdxW-1:0] clr_q, clr_d;
  logic two_src;

  assign two_src = (stat_i.kind == K_ADD) || (stat_i.kind == K_SUB) ||
                   (stat_i.kind == K_MUL) || (stat_i.kind == K_DIV);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == RegIdxW'(NumRegs - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = out_free_i;
        if (in_valid_i && out_free_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_RDA;
        end
      end
      S_RDA: begin
        cmd_o.rd_a = 1'b1;
        state_d = (two_src && stat_i.a_ok && stat_i.b_ok) ? S_RDB : S_WB;
      end
      S_RDB: begin
        cmd_o.rd_b = 1'b1;
        if (stat_i.kind == K_MUL) state_d = S_MUL1;
        else if (stat_i.kind == K_DIV) state_d = S_DIV;
        else state_d = S_WB;
      end
      S_MUL1: begin
        cmd_o.mul_lo = 1'b1;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_hi = 1'b1;
        state_d = S_WB;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_WB;
      end
      S_WB: begin
        cmd_o.write_back = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_RDB && stat_i.kind == K_DIV) cmd_o.div_start = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  assign clr_addr_o = clr_q;
  assign busy_o = (state_q != S_IDLE);
endmodule

>>> rtl/rbe_datapath.sv
// ----------------------------------------------------------------------------
// rbe_datapath
// Register file memory, operand registers, split multiplier, serial divider.
// ----------------------------------------------------------------------------
module rbe_datapath (
  input  logic            clk_i,
  input  rbe_pkg::cmd_t   cmd_i,
  input  logic [rbe_pkg::RegIdxW-1:0] clr_addr_i,
  input  rbe_pkg::instr_t instr_i,
  output rbe_pkg::stat_t  stat_o,
  output rbe_pkg::result_t res_o
);
  import rbe_pkg::*;

  logic [DataW-1:0] mem_q [NumRegs];
  instr_t ins_q;
  logic [DataW-1:0] x_q, y_q, rd_q;
  logic [RegIdxW-1:0] a_idx, b_idx;
  logic a_ok, b_ok;
  logic [8:0] a_p1;
  // multiply partials
  logic [63:0] pll_q;
  logic [31:0] plh_q, phl_q;
  // divider
  logic [63:0] rem_q, quo_q, dvs_q;
  logic [DivCntW-1:0] cnt_q;
  logic neg_q;
  logic [64:0] trial;
  logic [63:0] rem_sh;
  logic [63:0] mag_x, mag_y;
  logic [63:0] calc;
  logic [1:0] err;
  logic wr_en;

  assign a_p1  = {1'b0, ins_q.reg_index} + 9'd1;
  assign a_ok  = {1'b0, ins_q.reg_index} < 9'(NumRegs);
  assign b_ok  = a_p1 < 9'(NumRegs);
  assign a_idx = ins_q.reg_index[RegIdxW-1:0];
  assign b_idx = a_p1[RegIdxW-1:0];

  assign stat_o.kind     = ins_q.kind;
  assign stat_o.a_ok     = a_ok;
  assign stat_o.b_ok     = b_ok;
  assign stat_o.div_last = (cnt_q == DivCntW'(DataW - 1));

  assign mag_x  = x_q[63] ? (64'd0 - x_q) : x_q;
  assign mag_y  = rd_q[63] ? (64'd0 - rd_q) : rd_q;
  assign rem_sh = {rem_q[62:0], quo_q[63]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs_q};

  always_comb begin
    calc = x_q;
    err  = ERR_OK;
    case (ins_q.kind)
      K_LOADI:     calc = {56'd0, ins_q.imm_value};
      K_LOADINEG:  calc = 64'd0 - {56'd0, ins_q.imm_value};
      K_LOADSMALL: calc = {{60{ins_q.small_const[3]}}, ins_q.small_const};
      K_ADD:       calc = x_q + y_q;
      K_ADDI:      calc = x_q + {56'd0, ins_q.imm_value};
      K_SUB:       calc = x_q - y_q;
      K_SUBI:      calc = x_q - {56'd0, ins_q.imm_value};
      K_MUL:       calc = pll_q + {plh_q + phl_q, 32'd0};
      K_DIV: begin
        calc = neg_q ? (64'd0 - quo_q) : quo_q;
        if (y_q == 64'd0) err = ERR_DIVZERO;
      end
      default:     calc = x_q;
    endcase
    if (ins_q.kind == K_RETURN) err = a_ok ? ERR_OK : ERR_RANGE;
    else if (ins_q.kind >= K_LOADI && ins_q.kind <= K_DIV) begin
      if (!a_ok || (!b_ok && (ins_q.kind == K_ADD || ins_q.kind == K_SUB ||
                              ins_q.kind == K_MUL || ins_q.kind == K_DIV)))
        err = ERR_RANGE;
    end
    wr_en = cmd_i.write_back && (err == ERR_OK) &&
            (ins_q.kind >= K_LOADI) && (ins_q.kind <= K_DIV);
  end

  // Register file: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) mem_q[clr_addr_i] <= '0;
    else if (wr_en) mem_q[a_idx] <= calc;
    rd_q <= mem_q[cmd_i.capture ? instr_i.reg_index[RegIdxW-1:0] : b_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) ins_q <= instr_i;
    if (cmd_i.rd_a) x_q <= rd_q;
    if (cmd_i.rd_b) y_q <= rd_q;
    if (cmd_i.mul_lo) pll_q <= 64'(x_q[31:0] * y_q[31:0]);
    if (cmd_i.mul_hi) begin
      plh_q <= 32'(x_q[31:0] * y_q[63:32]);
      phl_q <= 32'(x_q[63:32] * y_q[31:0]);
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= mag_x;
      dvs_q <= mag_y;
      neg_q <= x_q[63] ^ rd_q[63];
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!trial[64]) rem_q <= trial[63:0];
      else rem_q <= rem_sh;
      quo_q <= {quo_q[62:0], ~trial[64]};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.write_back) begin
      res_o.done_res   <= (ins_q.kind == K_RETURN);
      res_o.ret_value  <= (ins_q.kind == K_RETURN && a_ok) ? x_q : 64'd0;
      res_o.error_code <= err;
    end
  end
endmodule

>>> rtl/register_bytecode_executor.sv
// Sequence: capture, read of r[a], read of r[a+1] (add, sub, mul, div), the two multiply
//   steps (mul) or the divider steps (div), then write-back; then the next input can be taken.
// One instruction at a time, limited by the single register-file read port and the
//   one-bit-per-cycle 64-step divider.
// Reset: asynchronous active low; afterwards a sweep zeroes the
//   register file while no instruction is taken.
// ----------------------------------------------------------------------------
// register_bytecode_executor
// Executes decoded register-machine instructions on a 64-bit register file.
// ----------------------------------------------------------------------------
`include "register_bytecode_executor_defines.svh"

module register_bytecode_executor (
  input  logic clk_i,
  input  logic rst_ni,
  rbe_instr_if.sink    in_i,
  rbe_result_if.source out_o
);
  import rbe_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  instr_t  instr;
  result_t res;
  logic [RegIdxW-1:0] clr_addr;
  logic busy;
  logic out_valid_q;
  logic out_free;

  // The result register is free when empty or drained this cycle.
  assign out_free = !out_valid_q || out_o.ready;

  assign instr.kind        = in_i.kind;
  assign instr.reg_index   = in_i.reg_index;
  assign instr.imm_value   = in_i.imm_value;
  assign instr.small_const = in_i.small_const;

  rbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .clr_addr_o (clr_addr),
    .busy_o     (busy)
  );

  rbe_datapath u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .clr_addr_i (clr_addr),
    .instr_i    (instr),
    .stat_o     (stat),
    .res_o      (res)
  );

  // Result valid: set on write-back, drop on transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd.write_back) out_valid_q <= 1'b1;
    else if (out_o.ready) out_valid_q <= 1'b0;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.done_res   = res.done_res;
  assign out_o.ret_value  = res.ret_value;
  assign out_o.error_code = res.error_code;

  // A new instruction is only taken while the sequencer idles.
  `RBE_ASSERT_IMPL(a_accept_idle, clk_i, rst_ni, in_i.valid && in_i.ready, !busy, "accept while busy")
  // Write-back never overruns a held result.
  `RBE_ASSERT_IMPL(a_no_overrun, clk_i, rst_ni, cmd.write_back, !out_valid_q || out_o.ready, "result overrun")
  // Only a return reports a value.
  `RBE_ASSERT_IMPL(a_ret_only, clk_i, rst_ni, out_o.valid && !out_o.done_res, out_o.ret_value == 64'd0, "stray value")
endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register bytecode executor testbench
// Drives decoded instructions through a directed table and then random
// programs, predicts each result from a shadow register file and compares it.
// ----------------------------------------------------------------------------
module tb_top;
  import rbe_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumRandom  = 660;

  logic clk_i;
  logic rst_ni;

  rbe_instr_if  instr_ch ();
  rbe_result_if result_ch ();

  register_bytecode_executor dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (instr_ch.sink),
    .out_o (result_ch.source)
  );

  // One row of the directed table; has_exp marks rows whose result is typed in.
  typedef struct {
    kind_e       kind;
    logic [7:0]  reg_index;
    logic [7:0]  imm_value;
    logic [3:0]  small_const;
    bit          has_exp;
    result_t     exp;
  } instr_row_t;

  logic [63:0] shadow_regs [NumRegs];
  result_t     pending_results [$];
  int unsigned error_count;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("** register_bytecode_executor: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Signed 64-bit division truncating toward zero; wraps on min / -1.
  function automatic logic [63:0] quotient_trunc(input logic [63:0] x,
                                                 input logic [63:0] y);
    logic [63:0] mx;
    logic [63:0] my;
    logic [63:0] q;
    mx = x[63] ? -x : x;
    my = y[63] ? -y : y;
    q  = mx / my;
    return (x[63] != y[63]) ? -q : q;
  endfunction

  // Execute one instruction on the shadow register file and give its result.
  function automatic result_t execute_instr(input logic [3:0] kind,
                                            input logic [7:0] a,
                                            input logic [7:0] b,
                                            input logic [3:0] sc);
    result_t     res;
    bit          a_ok;
    bit          b_ok;
    bit          two_src;
    logic [63:0] x;
    logic [63:0] y;
    res = '0;
    res.error_code = ERR_OK;
    a_ok = a < NumRegs;
    b_ok = (a + 9'd1) < NumRegs;
    two_src = kind inside {K_ADD, K_SUB, K_MUL, K_DIV};
    if (kind == K_RETURN) begin
      res.done_res = 1'b1;
      if (a_ok) res.ret_value = shadow_regs[a];
      else res.error_code = ERR_RANGE;
    end else if (kind >= K_LOADI && kind <= K_DIV) begin
      if (!a_ok || (two_src && !b_ok)) begin
        res.error_code = ERR_RANGE;
      end else begin
        x = shadow_regs[a];
        y = two_src ? shadow_regs[a + 1] : 64'd0;
        case (kind)
          K_LOADI:     x = {56'd0, b};
          K_LOADINEG:  x = -{56'd0, b};
          K_LOADSMALL: x = {{60{sc[3]}}, sc};
          K_ADD:       x = x + y;
          K_ADDI:      x = x + {56'd0, b};
          K_SUB:       x = x - y;
          K_SUBI:      x = x - {56'd0, b};
          K_MUL:       x = x * y;
          default: begin
            if (y == 64'd0) res.error_code = ERR_DIVZERO;
            else x = quotient_trunc(x, y);
          end
        endcase
        if (res.error_code == ERR_OK) shadow_regs[a] = x;
      end
    end
    return res;
  endfunction

  function automatic instr_row_t mk_row(kind_e k, logic [7:0] a, logic [7:0] b,
                                        logic [3:0] sc, bit has_exp = 1'b0,
                                        logic d = 1'b0, logic [63:0] v = '0,
                                        err_e e = ERR_OK);
    instr_row_t r;
    r.kind = k; r.reg_index = a; r.imm_value = b; r.small_const = sc;
    r.has_exp = has_exp;
    r.exp.done_res = d; r.exp.ret_value = v; r.exp.error_code = e;
    return r;
  endfunction

  // Hand one instruction over; hold it until the transfer completes.
  task automatic send_instr(input logic [3:0] kind, input logic [7:0] a,
                            input logic [7:0] b, input logic [3:0] sc,
                            input bit has_exp, input result_t exp);
    result_t pred;
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      instr_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    instr_ch.valid       <= 1'b1;
    instr_ch.kind        <= kind;
    instr_ch.reg_index   <= a;
    instr_ch.imm_value   <= b;
    instr_ch.small_const <= sc;
    do @(posedge clk_i); while (!instr_ch.ready);
    pred = execute_instr(kind, a, b, sc);
    if (has_exp && pred != exp)
      report_mismatch("typed-in expectation", pred[63:0], exp[63:0]);
    pending_results.push_back(pred);
  endtask

  // Sink side: random stalls on ready, compare each transfer field by field.
  initial begin
    result_t exp;
    int unsigned stall;
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(result_ch.valid && rst_ni));
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", result_ch.ret_value, 64'd0);
      end else begin
        exp = pending_results.pop_front();
        if (result_ch.done_res !== exp.done_res)
          report_mismatch("done_res", 64'(result_ch.done_res), 64'(exp.done_res));
        if (result_ch.ret_value !== exp.ret_value)
          report_mismatch("ret_value", result_ch.ret_value, exp.ret_value);
        if (result_ch.error_code !== exp.error_code)
          report_mismatch("error_code", 64'(result_ch.error_code), 64'(exp.error_code));
      end
    end
  end

  initial begin
    instr_row_t  dir_table [$];
    instr_row_t  min_row;
    int unsigned a;
    logic [3:0]  k;
    int unsigned r;
    result_t     none;
    none = '0;
    error_count = 0;
    cycle_count = 0;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    instr_ch.valid       = 1'b0;
    instr_ch.kind        = K_NOP;
    instr_ch.reg_index   = '0;
    instr_ch.imm_value   = '0;
    instr_ch.small_const = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: cleared file, extremes, error paths, min / -1.
    dir_table = '{
      mk_row(K_RETURN, 8'd255, 8'd0, 4'd0, 1'b1, 1'b1, 64'd0, ERR_OK),
      mk_row(K_NOP, 8'd0, 8'hff, 4'hf, 1'b1, 1'b0, 64'd0, ERR_OK),
      mk_row(K_LOADI, 8'd0, 8'hff, 4'd0, 1'b1, 1'b0, 64'd0, ERR_OK),
      mk_row(K_RETURN, 8'd0, 8'd0, 4'd0, 1'b1, 1'b1, 64'd255, ERR_OK),
      mk_row(K_LOADINEG, 8'd1, 8'hff, 4'd0),
      mk_row(K_LOADSMALL, 8'd2, 8'd0, 4'h8),
      mk_row(K_LOADSMALL, 8'd3, 8'd0, 4'h7),
      mk_row(K_LOADSMALL, 8'd4, 8'd0, 4'hf),
      mk_row(K_ADD, 8'd0, 8'd0, 4'd0),
      mk_row(K_SUB, 8'd1, 8'd0, 4'd0),
      mk_row(K_MUL, 8'd2, 8'd0, 4'd0),
      mk_row(K_ADDI, 8'd3, 8'hff, 4'd0),
      mk_row(K_SUBI, 8'd4, 8'hff, 4'd0),
      mk_row(K_DIV, 8'd5, 8'd0, 4'd0, 1'b1, 1'b0, 64'd0, ERR_DIVZERO),
      mk_row(K_DIV, 8'd1, 8'd0, 4'd0),
      mk_row(K_ADD, 8'd255, 8'd0, 4'd0, 1'b1, 1'b0, 64'd0, ERR_RANGE),
      mk_row(K_DIV, 8'd255, 8'd0, 4'd0, 1'b1, 1'b0, 64'd0, ERR_RANGE),
      mk_row(K_LOADI, 8'd255, 8'd1, 4'd0),
      mk_row(K_RETURN, 8'd255, 8'd0, 4'd0, 1'b1, 1'b1, 64'd1, ERR_OK),
      // Seed r10 and r11 with two for the doubling below.
      mk_row(K_LOADSMALL, 8'd10, 8'd0, 4'd2),
      mk_row(K_LOADSMALL, 8'd11, 8'd0, 4'd2),
      mk_row(K_NOP, 8'd0, 8'd0, 4'd0)
    };
    foreach (dir_table[i])
      send_instr(dir_table[i].kind, dir_table[i].reg_index, dir_table[i].imm_value,
                 dir_table[i].small_const, dir_table[i].has_exp, dir_table[i].exp);
    // Raise r10 to 2^63 by repeated doubling, then min / -1 and read back.
    for (int i = 0; i < 62; i++) begin
      send_instr(K_MUL, 8'd10, 8'd0, 4'd0, 1'b0, none);
    end
    send_instr(K_LOADSMALL, 8'd11, 8'd0, 4'hf, 1'b0, none);
    send_instr(K_DIV, 8'd10, 8'd0, 4'd0, 1'b0, none);
    min_row = mk_row(K_RETURN, 8'd10, 8'd0, 4'd0, 1'b1, 1'b1,
                     64'h8000_0000_0000_0000, ERR_OK);
    send_instr(min_row.kind, min_row.reg_index, min_row.imm_value,
               min_row.small_const, min_row.has_exp, min_row.exp);

    // Random programs on a small window of registers so values interact.
    for (int n = 0; n < NumRandom; n++) begin
      r = $urandom_range(0, 19);
      if (r == 0) a = $urandom_range(254, 255);
      else if (r == 1) a = $urandom_range(0, 255);
      else a = $urandom_range(0, 7);
      k = (r == 2) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
      send_instr(k, 8'(a), 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                 1'b0, none);
    end
    instr_ch.valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** register_bytecode_executor: PASSED **");
    end else begin
      $display("** register_bytecode_executor: FAILED **");
    end
    $finish;
  end

endmodule

>>> register_bytecode_executor.f
+incdir+rtl
rtl/rbe_pkg.sv
rtl/rbe_if.sv
rtl/rbe_ctrl.sv
rtl/rbe_datapath.sv
rtl/register_bytecode_executor.sv
dv/tb_top.sv
